/* sv/sbeq_pkg.sv */
// Shared types, constants and Q15 helpers for the stereo biquad equalizer.
// No dependencies; imported by sbeq_mac and stereo_cascaded_biquad_eq.
`default_nettype none

package sbeq_pkg;

	localparam int SBEQ_NUM_BANDS = 12;

	localparam int COEF_W  = 16;
	localparam int DATA_W  = 32;
	localparam int PROD_W  = COEF_W + DATA_W;
	localparam int Q15_SHIFT = 15;

	localparam logic signed [DATA_W-1:0] Q15_MAX = 32'sd32767;
	localparam logic signed [DATA_W-1:0] Q15_MIN = -32'sd32768;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_BAND  = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
		logic [3:0]         band;
		logic signed [31:0] coef_b0;
		logic signed [31:0] coef_b1;
		logic signed [31:0] coef_b2;
		logic signed [31:0] coef_a1;
		logic signed [31:0] coef_a2;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic [1:0]         clip_flags;
	} out_beat_t;

	// one coefficient row per band
	typedef struct packed {
		logic signed [COEF_W-1:0] a2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b0;
	} coef_row_t;

	// one history row per band and channel
	typedef struct packed {
		logic signed [DATA_W-1:0] y2;
		logic signed [DATA_W-1:0] y1;
		logic signed [DATA_W-1:0] x2;
		logic signed [DATA_W-1:0] x1;
	} hist_row_t;

	typedef struct packed {
		logic mul_en;
		logic first;
		logic sub;
	} mac_ctl_t;

	function automatic logic clip_q15(input logic signed [DATA_W-1:0] v);
		return (v > Q15_MAX) || (v < Q15_MIN);
	endfunction

	function automatic logic signed [COEF_W-1:0] sat_q15(input logic signed [DATA_W-1:0] v);
		logic signed [COEF_W-1:0] r;
		if (v > Q15_MAX) begin
			r = Q15_MAX[COEF_W-1:0];
		end else if (v < Q15_MIN) begin
			r = Q15_MIN[COEF_W-1:0];
		end else begin
			r = v[COEF_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/sbeq_mac.sv */
// Shared Q15 multiply-accumulate unit: registered 16x32 product, floor shift, wrapping sum.
// Depends on sbeq_pkg.
`default_nettype none

module sbeq_mac (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire sbeq_pkg::mac_ctl_t      ctl,
	input  wire signed [15:0]            coef,
	input  wire signed [31:0]            value,
	output logic signed [31:0]           acc_next
);
	import sbeq_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	mac_ctl_t                 ctl_s1;
	logic signed [DATA_W-1:0] acc_q;
	logic signed [DATA_W-1:0] term;
	logic signed [DATA_W-1:0] base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= PROD_W'(coef) * PROD_W'(value);
		end
	end

	// floor shift is a plain slice of the two's complement product
	assign term = prod_s1[Q15_SHIFT+DATA_W-1:Q15_SHIFT];
	assign base = ctl_s1.first ? '0 : acc_q;
	assign acc_next = ctl_s1.sub ? (base - term) : (base + term);

	always_ff @(posedge clk) begin
		if (ctl_s1.mul_en) begin
			acc_q <= acc_next;
		end
	end

endmodule

`default_nettype wire

/* sv/stereo_cascaded_biquad_eq.sv */
// Stereo cascaded Q15 biquad equalizer: sequencer, coefficient and history memories.
// Depends on sbeq_pkg and sbeq_mac.
//
//  channel | valid        | stall        | payload            | beat
//  --------+--------------+--------------+--------------------+------------------------------
//  input   | frame_valid  | frame_stall  | frame  (in_beat_t) | stereo frame or band write
//  output  | result_valid | result_stall | result (out_beat_t)| filtered frame and clip flags
//
// A frame passes from accept to result through one memory read, then for each band and
// channel five products through the single multiplier plus one history writeback step that
// also fetches the next rows, then the output state, which loads the result register once it
// is free. The input takes its next beat when the output state hands back to idle. A band
// write is taken while idle, needs no further state and gives no beat.
// Reset clears control state and the per-row valid bits, so all coefficients and history
// read as zero. The finished frame waits in the result register; a new input beat is taken
// meanwhile, and a second result holds in the output state until the register is free.
`default_nettype none

module stereo_cascaded_biquad_eq #(
	parameter int NUM_BANDS = sbeq_pkg::SBEQ_NUM_BANDS
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  frame_valid,
	output logic                 frame_stall,
	input  wire sbeq_pkg::in_beat_t frame,
	output logic                 result_valid,
	input  wire                  result_stall,
	output sbeq_pkg::out_beat_t  result
);
	import sbeq_pkg::*;

	localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
	localparam int ROWS   = 2 * NUM_BANDS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_LAST = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam logic [2:0] K_B0 = 3'd0;
	localparam logic [2:0] K_B1 = 3'd1;
	localparam logic [2:0] K_B2 = 3'd2;
	localparam logic [2:0] K_A1 = 3'd3;
	localparam logic [2:0] K_A2 = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        k_q;
	logic [BAND_W-1:0] band_q;
	logic              ch_q;
	logic [BAND_W-1:0] band_nx;
	logic              last_unit;

	logic signed [DATA_W-1:0] x_q [2];

	coef_row_t coef_mem [NUM_BANDS];
	hist_row_t hist_mem [ROWS];
	logic [NUM_BANDS-1:0] coef_valid_q;
	logic [ROWS-1:0]      hist_valid_q;

	coef_row_t coef_rd_q;
	hist_row_t hist_rd_q;
	logic      coef_ok_q;
	logic      hist_ok_q;
	coef_row_t coef_cur;
	hist_row_t hist_cur;

	logic              rd_en;
	logic [BAND_W-1:0] rd_band;
	logic              rd_ch;

	logic              accept;
	logic              band_wr;
	logic [BAND_W-1:0] wr_band;
	coef_row_t         wr_row;
	logic              hist_we;
	hist_row_t         hist_new;

	mac_ctl_t                 mac_ctl;
	logic signed [COEF_W-1:0] mac_coef;
	logic signed [DATA_W-1:0] mac_value;
	logic signed [DATA_W-1:0] acc_next;

	out_beat_t result_q;
	logic      result_valid_q;
	logic      out_load;

	assign frame_stall = (state_q != ST_IDLE);
	assign accept      = frame_valid && !frame_stall;
	assign wr_band     = BAND_W'(32'(frame.band));
	assign band_wr     = accept && (frame.op == OP_BAND)
		&& ({28'd0, frame.band} < 32'(NUM_BANDS));

	assign wr_row.b0 = sat_q15(frame.coef_b0);
	assign wr_row.b1 = sat_q15(frame.coef_b1);
	assign wr_row.b2 = sat_q15(frame.coef_b2);
	assign wr_row.a1 = sat_q15(frame.coef_a1);
	assign wr_row.a2 = sat_q15(frame.coef_a2);

	assign band_nx   = ch_q ? BAND_W'(band_q + 1'b1) : band_q;
	assign last_unit = (band_q == BAND_W'(NUM_BANDS - 1)) && ch_q;

	// fetch the next unit's rows during writeback of the current one
	assign rd_en   = (state_q == ST_READ) || ((state_q == ST_LAST) && !last_unit);
	assign rd_band = (state_q == ST_LAST) ? band_nx : band_q;
	assign rd_ch   = (state_q == ST_LAST) ? !ch_q : ch_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			coef_rd_q <= coef_mem[rd_band];
			hist_rd_q <= hist_mem[{rd_band, rd_ch}];
		end
	end

	always_ff @(posedge clk) begin
		if (band_wr) begin
			coef_mem[wr_band] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[{band_q, ch_q}] <= hist_new;
		end
	end

	assign coef_cur = coef_ok_q ? coef_rd_q : '0;
	assign hist_cur = hist_ok_q ? hist_rd_q : '0;

	assign hist_we     = (state_q == ST_LAST);
	assign hist_new.x1 = x_q[ch_q];
	assign hist_new.x2 = hist_cur.x1;
	assign hist_new.y1 = acc_next;
	assign hist_new.y2 = hist_cur.y1;

	always_comb begin
		mac_ctl   = '0;
		mac_coef  = '0;
		mac_value = '0;
		if (state_q == ST_MAC) begin
			mac_ctl.mul_en = 1'b1;
			mac_ctl.first  = (k_q == K_B0);
			unique case (k_q)
				K_B0: begin
					mac_coef  = coef_cur.b0;
					mac_value = x_q[ch_q];
				end
				K_B1: begin
					mac_coef  = coef_cur.b1;
					mac_value = hist_cur.x1;
				end
				K_B2: begin
					mac_coef  = coef_cur.b2;
					mac_value = hist_cur.x2;
				end
				K_A1: begin
					mac_coef    = coef_cur.a1;
					mac_value   = hist_cur.y1;
					mac_ctl.sub = 1'b1;
				end
				K_A2: begin
					mac_coef    = coef_cur.a2;
					mac_value   = hist_cur.y2;
					mac_ctl.sub = 1'b1;
				end
				default: begin
					mac_coef  = '0;
					mac_value = '0;
				end
			endcase
		end
	end

	sbeq_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.coef     (mac_coef),
		.value    (mac_value),
		.acc_next (acc_next)
	);

	assign out_load = (state_q == ST_OUT) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			k_q            <= K_B0;
			band_q         <= '0;
			ch_q           <= 1'b0;
			coef_valid_q   <= '0;
			hist_valid_q   <= '0;
			coef_ok_q      <= 1'b0;
			hist_ok_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				coef_ok_q <= coef_valid_q[rd_band];
				hist_ok_q <= hist_valid_q[{rd_band, rd_ch}];
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (band_wr) begin
						coef_valid_q[wr_band]         <= 1'b1;
						hist_valid_q[{wr_band, 1'b0}] <= 1'b0;
						hist_valid_q[{wr_band, 1'b1}] <= 1'b0;
					end
					if (accept && (frame.op == OP_FRAME)) begin
						band_q  <= '0;
						ch_q    <= 1'b0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					k_q     <= K_B0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (k_q == K_A2) begin
						state_q <= ST_LAST;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_LAST: begin
					hist_valid_q[{band_q, ch_q}] <= 1'b1;
					k_q <= K_B0;
					if (last_unit) begin
						state_q <= ST_OUT;
					end else begin
						band_q  <= band_nx;
						ch_q    <= !ch_q;
						state_q <= ST_MAC;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// channel samples and band outputs; hold each channel's running value
	always_ff @(posedge clk) begin
		if (accept && (frame.op == OP_FRAME)) begin
			x_q[0] <= {{16{frame.left_in[15]}}, frame.left_in};
			x_q[1] <= {{16{frame.right_in[15]}}, frame.right_in};
		end else if (state_q == ST_LAST) begin
			x_q[ch_q] <= acc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.left_out   <= sat_q15(x_q[0]);
			result_q.right_out  <= sat_q15(x_q[1]);
			result_q.clip_flags <= {clip_q15(x_q[1]), clip_q15(x_q[0])};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_frame_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (frame.op == OP_FRAME)) |=> (state_q == ST_READ) && (band_q == '0) && !ch_q)
		else $error("frame did not start at the first band");

	a_chain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LAST) && last_unit) |=> (state_q == ST_OUT))
		else $error("last band did not lead to output");

	a_band_write: assert property (@(posedge clk) disable iff (!arst_n)
		band_wr |=> coef_valid_q[$past(wr_band)] && !hist_valid_q[{$past(wr_band), 1'b0}]
			&& !hist_valid_q[{$past(wr_band), 1'b1}])
		else $error("band write did not mark coefficients valid and clear history");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside the output state");

endmodule

`default_nettype wire
